// File: hdl/sorted_integer_set_assert.svh
// assertion macros for the sorted integer set
`ifndef SORTED_INTEGER_SET_ASSERT_SVH
`define SORTED_INTEGER_SET_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SIS_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("sorted_integer_set: label failed");

// next-cycle implication, checked outside reset
`define SIS_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("sorted_integer_set: label failed");

`endif

// File: hdl/sis_pkg.sv
// shared constants and types for the sorted integer set
`default_nettype none

package sis_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int KEY_W        = 32;
  localparam int KIND_W       = 2;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_MEMBER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RANGE  = 2'd3;

  // cell commands
  localparam logic [1:0] CMD_HOLD   = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;
  localparam logic [1:0] CMD_RANGE  = 2'd3;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [KEY_W-1:0] key;
    logic signed [KEY_W-1:0] key_high;
  } cell_cmd_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic                    lt;   // occupied and below key
    logic                    eq;   // occupied and equal to key
    logic                    gt;   // occupied and above key
    logic                    inr;  // occupied and strictly inside the range
  } cell_stat_t;

endpackage

`default_nettype wire

// File: hdl/sorted_integer_set.sv
// sorted integer set: top level with request sequencer and chain of key cells
//
// Keeps up to CAPACITY distinct signed keys in ascending order, one per cell.
// Input channel in_valid/in_stall carries kind, key and key_high; the output
// channel out_valid/out_stall returns found, rejected_full, removed and size,
// exactly one result transaction per request, in request order.
// Member test, insert and single delete are resolved in the accept cycle by a
// broadcast compare in every cell; the result is registered at the end of the
// accept cycle; a new request can be taken every cycle while no result is stalled.
// A range delete removes one key per cycle by shifting the chain down: after
// its accept cycle it keeps in_stall high until no key lies inside the range
// and the output is free, and only then registers its result.
// A request is accepted only in a cycle in which no result waits or the
// waiting result is taken; while out_stall holds a result, in_stall stays high.
// Synchronous reset empties the set at once (no clearing pass); cell contents
// beyond the count are never read.
`default_nettype none

module sorted_integer_set #(
  parameter int CAPACITY = sis_pkg::CAPACITY_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [sis_pkg::KIND_W-1:0]            in_kind,
  input  wire logic signed [sis_pkg::KEY_W-1:0]      in_key,
  input  wire logic signed [sis_pkg::KEY_W-1:0]      in_key_high,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic                                       out_found,
  output logic                                       out_rejected_full,
  output logic [$clog2(CAPACITY+1)-1:0]              out_removed,
  output logic [$clog2(CAPACITY+1)-1:0]              out_size
);

  `include "sorted_integer_set_assert.svh"

  localparam int CW = $clog2(CAPACITY+1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  sis_pkg::cell_cmd_t  cmd;
  sis_pkg::cell_stat_t stat [CAPACITY];
  sis_pkg::cell_stat_t left_stat [CAPACITY];
  sis_pkg::cell_stat_t right_stat [CAPACITY];
  logic [CAPACITY-1:0] eq_vec;
  logic [CAPACITY-1:0] inr_vec;

  logic [CW-1:0] count_r, count_nxt;
  logic          busy_r, busy_nxt;
  logic [CW-1:0] removed_r, removed_nxt;
  logic signed [sis_pkg::KEY_W-1:0] lo_r, hi_r;

  logic          out_valid_r, out_valid_nxt;
  logic          out_found_r, out_found_nxt;
  logic          out_rejected_full_r, out_rejected_full_nxt;
  logic [CW-1:0] out_removed_r, out_removed_nxt;
  logic [CW-1:0] out_size_r, out_size_nxt;

  logic accept, out_free, found, any_inr, full, finish;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        // the first cell sees a neighbor below every key
        assign left_stat[gi] = '{key: stat[gi].key, lt: 1'b1, eq: 1'b0, gt: 1'b0,
                                 inr: 1'b0};
      end else begin : g_mid
        assign left_stat[gi] = stat[gi-1];
      end
      if (gi == CAPACITY-1) begin : g_last
        assign right_stat[gi] = stat[gi];
      end else begin : g_rest
        assign right_stat[gi] = stat[gi+1];
      end

      sis_cell #(
        .CAPACITY (CAPACITY),
        .IDX      (gi)
      ) u_cell (
        .clk        (clk),
        .count      (count_r),
        .cmd        (cmd),
        .left_stat  (left_stat[gi]),
        .right_stat (right_stat[gi]),
        .stat       (stat[gi])
      );

      assign eq_vec[gi]  = stat[gi].eq;
      assign inr_vec[gi] = stat[gi].inr;
    end
  endgenerate

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = busy_r || !out_free;
  assign accept   = in_valid && !in_stall;
  assign found    = |eq_vec;
  assign any_inr  = |inr_vec;
  assign full     = count_r == CAP_C;
  assign finish   = busy_r && !any_inr && out_free;

  always_comb begin
    cmd.key      = busy_r ? lo_r : in_key;
    cmd.key_high = busy_r ? hi_r : in_key_high;
    cmd.op       = sis_pkg::CMD_HOLD;
    count_nxt    = count_r;
    busy_nxt     = busy_r;
    removed_nxt  = removed_r;

    out_valid_nxt         = out_valid_r && out_stall;
    out_found_nxt         = out_found_r;
    out_rejected_full_nxt = out_rejected_full_r;
    out_removed_nxt       = out_removed_r;
    out_size_nxt          = out_size_r;

    if (busy_r) begin
      if (any_inr) begin
        cmd.op      = sis_pkg::CMD_RANGE;
        count_nxt   = count_r - ONE_C;
        removed_nxt = removed_r + ONE_C;
      end else if (finish) begin
        busy_nxt              = 1'b0;
        out_valid_nxt         = 1'b1;
        out_found_nxt         = 1'b0;
        out_rejected_full_nxt = 1'b0;
        out_removed_nxt       = removed_r;
        out_size_nxt          = count_r;
      end
    end else if (accept) begin
      out_found_nxt         = found;
      out_rejected_full_nxt = 1'b0;
      out_removed_nxt       = '0;
      unique case (in_kind)
        sis_pkg::KIND_INSERT: begin
          if (!found && full) begin
            out_rejected_full_nxt = 1'b1;
          end else if (!found) begin
            cmd.op    = sis_pkg::CMD_INSERT;
            count_nxt = count_r + ONE_C;
          end
        end
        sis_pkg::KIND_DELETE: begin
          if (found) begin
            cmd.op          = sis_pkg::CMD_DELETE;
            count_nxt       = count_r - ONE_C;
            out_removed_nxt = ONE_C;
          end
        end
        sis_pkg::KIND_RANGE: begin
          busy_nxt    = 1'b1;
          removed_nxt = '0;
        end
        default: cmd.op = sis_pkg::CMD_HOLD;
      endcase
      if (in_kind != sis_pkg::KIND_RANGE) begin
        out_valid_nxt = 1'b1;
        out_size_nxt  = count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    removed_r           <= removed_nxt;
    out_found_r         <= out_found_nxt;
    out_rejected_full_r <= out_rejected_full_nxt;
    out_removed_r       <= out_removed_nxt;
    out_size_r          <= out_size_nxt;
    if (accept) begin
      lo_r <= in_key;
      hi_r <= in_key_high;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_rejected_full = out_rejected_full_r;
  assign out_removed       = out_removed_r;
  assign out_size          = out_size_r;

  `SIS_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CAP_C)
  `SIS_ASSERT_NEXT(a_range_step, busy_r && any_inr, count_r == $past(count_r) - ONE_C)
  `SIS_ASSERT_NOW(a_size_tracks, out_valid_r && !busy_r, out_size_r == count_r)
  `SIS_ASSERT_NOW(a_reject_clean, out_valid_r && out_rejected_full_r,
                  !out_found_r && out_removed_r == '0 && out_size_r == CAP_C)

endmodule

`default_nettype wire

// File: hdl/sis_cell.sv
// one slot of the sorted key chain: compare against the broadcast key and shift
`default_nettype none

module sis_cell #(
  parameter int CAPACITY = sis_pkg::CAPACITY_DEF,
  parameter int IDX      = 0
) (
  input  wire logic                         clk,
  input  wire logic [$clog2(CAPACITY+1)-1:0] count,
  input  wire sis_pkg::cell_cmd_t           cmd,
  input  wire sis_pkg::cell_stat_t          left_stat,
  input  wire sis_pkg::cell_stat_t          right_stat,
  output sis_pkg::cell_stat_t               stat
);

  localparam int CW = $clog2(CAPACITY+1);
  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  logic signed [sis_pkg::KEY_W-1:0] key_r;
  logic signed [sis_pkg::KEY_W-1:0] key_nxt;
  logic                             occ;

  assign occ = count > IDX_C;

  always_comb begin
    stat.key = key_r;
    stat.lt  = occ && (key_r < cmd.key);
    stat.eq  = occ && (key_r == cmd.key);
    stat.gt  = occ && (key_r > cmd.key);
    stat.inr = occ && (key_r > cmd.key) && (key_r < cmd.key_high);
  end

  always_comb begin
    key_nxt = key_r;
    unique case (cmd.op)
      sis_pkg::CMD_INSERT: begin
        // the first slot not below the key takes it, the rest move up one
        if (!stat.lt) begin
          key_nxt = left_stat.lt ? cmd.key : left_stat.key;
        end
      end
      sis_pkg::CMD_DELETE: begin
        if (!stat.lt) begin
          key_nxt = right_stat.key;
        end
      end
      sis_pkg::CMD_RANGE: begin
        // everything above the low bound moves down, dropping the first in range
        if (stat.gt) begin
          key_nxt = right_stat.key;
        end
      end
      default: key_nxt = key_r;
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

`default_nettype wire
